// File: sv/tpmde_pkg.sv
// shared types and constants of the torsion pair min distance energy block
package tpmde_pkg;

  localparam int unsigned ANGLE_W  = 15;
  localparam int unsigned DIFF_W   = ANGLE_W + 1;
  localparam int unsigned MAG_W    = ANGLE_W;
  localparam int unsigned MCD_W    = 2 * MAG_W;
  localparam int unsigned RAD_W    = 32;
  localparam int unsigned ROOT_W   = RAD_W / 2;
  localparam int unsigned REM_W    = ROOT_W + 1;
  localparam int unsigned SUM_W    = 27;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned SQ_STEPS = MAG_W;
  localparam int unsigned RT_STEPS = ROOT_W;
  localparam int unsigned CNT_W    = $clog2(RT_STEPS);

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam logic signed [ANGLE_W-1:0] HELIX_PHI_RST = -15'sd3699;
  localparam logic signed [ANGLE_W-1:0] HELIX_PSI_RST = -15'sd3008;
  localparam logic signed [ANGLE_W-1:0] SHEET_PHI_RST = -15'sd7616;
  localparam logic signed [ANGLE_W-1:0] SHEET_PSI_RST = 15'sd7232;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HELIX_PHI = 2'd0,
    REG_HELIX_PSI = 2'd1,
    REG_SHEET_PHI = 2'd2,
    REG_SHEET_PSI = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic load;
    logic sq_step;
    logic rt_step;
  } lane_ctrl_t;

endpackage

// File: sv/tpmde_lane.sv
// one distance lane: bit-serial sum of squares, then two-bit-per-step integer root
module tpmde_lane (
  input  logic                                  clk_i,
  input  tpmde_pkg::lane_ctrl_t                 ctrl_i,
  input  logic signed [tpmde_pkg::ANGLE_W-1:0]  phi_i,
  input  logic signed [tpmde_pkg::ANGLE_W-1:0]  psi_i,
  input  logic signed [tpmde_pkg::ANGLE_W-1:0]  ref_phi_i,
  input  logic signed [tpmde_pkg::ANGLE_W-1:0]  ref_psi_i,
  output logic        [tpmde_pkg::ROOT_W-1:0]   dist_o
);

  logic signed [tpmde_pkg::DIFF_W-1:0] dp, ds, abs_p, abs_s;
  logic [tpmde_pkg::MAG_W-1:0]  mlt_p_q, mlt_p_d, mlt_s_q, mlt_s_d;
  logic [tpmde_pkg::MCD_W-1:0]  mcd_p_q, mcd_p_d, mcd_s_q, mcd_s_d;
  logic [tpmde_pkg::RAD_W-1:0]  acc_q, acc_d, add_p, add_s;
  logic [tpmde_pkg::REM_W-1:0]  rem_q, rem_d;
  logic [tpmde_pkg::ROOT_W-1:0] root_q, root_d;
  logic [tpmde_pkg::REM_W+1:0]  rem_sh, trial, rem_sub;
  logic                         ge;

  assign dp    = {phi_i[tpmde_pkg::ANGLE_W-1], phi_i} - {ref_phi_i[tpmde_pkg::ANGLE_W-1], ref_phi_i};
  assign ds    = {psi_i[tpmde_pkg::ANGLE_W-1], psi_i} - {ref_psi_i[tpmde_pkg::ANGLE_W-1], ref_psi_i};
  assign abs_p = dp[tpmde_pkg::DIFF_W-1] ? -dp : dp;
  assign abs_s = ds[tpmde_pkg::DIFF_W-1] ? -ds : ds;

  assign add_p = mlt_p_q[0] ? {{(tpmde_pkg::RAD_W-tpmde_pkg::MCD_W){1'b0}}, mcd_p_q} : '0;
  assign add_s = mlt_s_q[0] ? {{(tpmde_pkg::RAD_W-tpmde_pkg::MCD_W){1'b0}}, mcd_s_q} : '0;

  assign rem_sh  = {rem_q, acc_q[tpmde_pkg::RAD_W-1 -: 2]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign ge      = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;

  always_comb begin
    mlt_p_d = mlt_p_q;
    mlt_s_d = mlt_s_q;
    mcd_p_d = mcd_p_q;
    mcd_s_d = mcd_s_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    root_d  = root_q;
    if (ctrl_i.load) begin
      mlt_p_d = abs_p[tpmde_pkg::MAG_W-1:0];
      mlt_s_d = abs_s[tpmde_pkg::MAG_W-1:0];
      mcd_p_d = {{tpmde_pkg::MAG_W{1'b0}}, abs_p[tpmde_pkg::MAG_W-1:0]};
      mcd_s_d = {{tpmde_pkg::MAG_W{1'b0}}, abs_s[tpmde_pkg::MAG_W-1:0]};
      acc_d   = '0;
      rem_d   = '0;
      root_d  = '0;
    end else if (ctrl_i.sq_step) begin
      acc_d   = acc_q + add_p + add_s;
      mlt_p_d = mlt_p_q >> 1;
      mlt_s_d = mlt_s_q >> 1;
      mcd_p_d = mcd_p_q << 1;
      mcd_s_d = mcd_s_q << 1;
    end else if (ctrl_i.rt_step) begin
      acc_d  = {acc_q[tpmde_pkg::RAD_W-3:0], 2'b00};
      rem_d  = ge ? rem_sub[tpmde_pkg::REM_W-1:0] : rem_sh[tpmde_pkg::REM_W-1:0];
      root_d = {root_q[tpmde_pkg::ROOT_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    mlt_p_q <= mlt_p_d;
    mlt_s_q <= mlt_s_d;
    mcd_p_q <= mcd_p_d;
    mcd_s_q <= mcd_s_d;
    acc_q   <= acc_d;
    rem_q   <= rem_d;
    root_q  <= root_d;
  end

  assign dist_o = root_q;

endmodule

// File: sv/torsion_pair_min_distance_energy.sv
// top level: two distance lanes, minimum, saturating sum and result register
//
// channel | direction | handshake             | payload
// input   | in        | in_valid_i/in_ready_o | phi_angle_i, psi_angle_i, last_residue_i
// output  | out       | out_valid_o/out_ready_i | energy_total_o, saturated_o
// config  | in        | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// a transaction runs through accept, 15 bit-serial squaring steps,
// 16 root steps (two radicand bits each) and an accumulate state
// both lanes run side by side
// reset clears the sum, the flag and the state and sets the references to their defaults
// a last transaction waits in the accumulate state while an earlier result is not taken
module torsion_pair_min_distance_energy (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [tpmde_pkg::ANGLE_W-1:0]  phi_angle_i,
  input  logic signed [tpmde_pkg::ANGLE_W-1:0]  psi_angle_i,
  input  logic                                  last_residue_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic        [tpmde_pkg::SUM_W-1:0]    energy_total_o,
  output logic                                  saturated_o,
  input  logic                                  cfg_we_i,
  input  logic        [tpmde_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic        [tpmde_pkg::ANGLE_W-1:0]  cfg_data_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SQ   = 2'd1;
  localparam logic [1:0] ST_RT   = 2'd2;
  localparam logic [1:0] ST_ACC  = 2'd3;

  logic [1:0] state_q, state_d;
  logic [tpmde_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic last_q, last_d;

  logic signed [tpmde_pkg::ANGLE_W-1:0] helix_phi_q, helix_psi_q, sheet_phi_q, sheet_psi_q;

  logic [tpmde_pkg::SUM_W-1:0] sum_q, sum_d, sum_new;
  logic clip_q, clip_d, clip_new;
  logic out_valid_q, out_valid_d;
  logic [tpmde_pkg::SUM_W-1:0] energy_q, energy_d;
  logic sat_q, sat_d;

  tpmde_pkg::lane_ctrl_t ctrl;
  logic [tpmde_pkg::ROOT_W-1:0] dist_helix, dist_sheet, dist_min;
  logic [tpmde_pkg::SUM_W:0] sum_ext;
  logic accept, acc_go;

  assign in_ready_o = state_q == ST_IDLE;
  assign accept     = in_valid_i && in_ready_o;
  assign acc_go     = !(last_q && out_valid_q && !out_ready_i);

  assign ctrl.load    = accept;
  assign ctrl.sq_step = state_q == ST_SQ;
  assign ctrl.rt_step = state_q == ST_RT;

  tpmde_lane u_lane_helix (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .phi_i     (phi_angle_i),
    .psi_i     (psi_angle_i),
    .ref_phi_i (helix_phi_q),
    .ref_psi_i (helix_psi_q),
    .dist_o    (dist_helix)
  );

  tpmde_lane u_lane_sheet (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .phi_i     (phi_angle_i),
    .psi_i     (psi_angle_i),
    .ref_phi_i (sheet_phi_q),
    .ref_psi_i (sheet_psi_q),
    .dist_o    (dist_sheet)
  );

  assign dist_min = (dist_helix < dist_sheet) ? dist_helix : dist_sheet;
  assign sum_ext  = {1'b0, sum_q}
                  + {{(tpmde_pkg::SUM_W+1-tpmde_pkg::ROOT_W){1'b0}}, dist_min};
  assign sum_new  = sum_ext[tpmde_pkg::SUM_W] ? tpmde_pkg::SUM_MAX
                                              : sum_ext[tpmde_pkg::SUM_W-1:0];
  assign clip_new = clip_q | sum_ext[tpmde_pkg::SUM_W];

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    sum_d       = sum_q;
    clip_d      = clip_q;
    energy_d    = energy_q;
    sat_d       = sat_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          last_d  = last_residue_i;
          cnt_d   = '0;
          state_d = ST_SQ;
        end
      end
      ST_SQ: begin
        if (cnt_q == tpmde_pkg::CNT_W'(tpmde_pkg::SQ_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = ST_RT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_RT: begin
        if (cnt_q == tpmde_pkg::CNT_W'(tpmde_pkg::RT_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = ST_ACC;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_ACC: begin
        if (acc_go) begin
          state_d = ST_IDLE;
          if (last_q) begin
            energy_d    = sum_new;
            sat_d       = clip_new;
            out_valid_d = 1'b1;
            sum_d       = '0;
            clip_d      = 1'b0;
          end else begin
            sum_d  = sum_new;
            clip_d = clip_new;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      last_q      <= 1'b0;
      sum_q       <= '0;
      clip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      last_q      <= last_d;
      sum_q       <= sum_d;
      clip_q      <= clip_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    energy_q <= energy_d;
    sat_q    <= sat_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      helix_phi_q <= tpmde_pkg::HELIX_PHI_RST;
      helix_psi_q <= tpmde_pkg::HELIX_PSI_RST;
      sheet_phi_q <= tpmde_pkg::SHEET_PHI_RST;
      sheet_psi_q <= tpmde_pkg::SHEET_PSI_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tpmde_pkg::REG_HELIX_PHI: helix_phi_q <= cfg_data_i;
        tpmde_pkg::REG_HELIX_PSI: helix_psi_q <= cfg_data_i;
        tpmde_pkg::REG_SHEET_PHI: sheet_phi_q <= cfg_data_i;
        tpmde_pkg::REG_SHEET_PSI: sheet_psi_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign energy_total_o = energy_q;
  assign saturated_o    = sat_q;

endmodule

// File: sv/tpmde_checker.sv
// port checker for the torsion pair min distance energy block, with its bind
module tpmde_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_ready_o,
  input logic                                  out_valid_o,
  input logic                                  out_ready_i,
  input logic        [tpmde_pkg::SUM_W-1:0]    energy_total_o,
  input logic                                  saturated_o
);

  // the input stays busy after a transaction is accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o)
    else $error("input taken again too early");

  // a new result only comes out of the busy phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without work in flight");

  // a clipped result always reads full scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> energy_total_o == tpmde_pkg::SUM_MAX)
    else $error("clip flag with partial sum");

  // a pending result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(energy_total_o)
      && $stable(saturated_o))
    else $error("result dropped or changed while stalled");

endmodule

bind torsion_pair_min_distance_energy tpmde_checker u_tpmde_checker (.*);
